/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the tour builder, included by nearest_neighbour_tour.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks a property on every rising edge of clk, held off while rst_n is low.
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/nnt_pkg.sv */
// Types and constants of the nearest-neighbour tour builder.
package nnt_pkg;

    // Fixed field widths.
    localparam int CITY_W  = 5;
    localparam int COUNT_W = 6;
    localparam int COST_W  = 21;

    // Most tour positions one run may produce.
    localparam int RESULT_LIMIT = 32;

    // Saturation value of the tour cost.
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Reset value of the city count register.
    localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = 6'd32;

    // Operation codes of an input beat.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_RET   = 7'b0010000,
        S_RETW  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

endpackage

/* hdl/nearest_neighbour_tour.sv */
// Greedy nearest-neighbour tour builder over a stored distance matrix.
//
// Input channel (in_valid/in_ready): a load beat (operation 0) writes one
// distance entry at row from_city, column to_city and gives no result. A
// solve beat (operation 1) builds a tour from start_city over the first
// city_count cities, clamped to 1 through min(MAX_CITIES, 32), and gives
// one output beat per position. Output channel (out_valid/out_ready):
// position, city, and on the final beat last = 1 with the closed tour cost,
// the return edge included. The configuration register city_count is
// written through cfg_we/cfg_wdata. One distance memory read port and one
// compare unit are shared by all steps: each tour position after the first
// scans n entries, drains the registered read and picks the nearest, and
// the final position adds a read of the return edge.
// in_ready is low from the solve beat until the last output beat is taken.
// A stalled receiver holds the block in its output state with the beat
// unchanged. Reset clears the sequencer and sets city_count to 32; the
// distance memory keeps no reset value and must be loaded before use.
module nearest_neighbour_tour #(
    parameter int MAX_CITIES = 32,
    parameter int DIST_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [nnt_pkg::COUNT_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [nnt_pkg::CITY_W-1:0]   from_city,
    input  logic [nnt_pkg::CITY_W-1:0]   to_city,
    input  logic [15:0]                  distance,
    input  logic [nnt_pkg::CITY_W-1:0]   start_city,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [nnt_pkg::CITY_W-1:0]   position,
    output logic [nnt_pkg::CITY_W-1:0]   city,
    output logic                         last,
    output logic [nnt_pkg::COST_W-1:0]   tour_cost
);

    import nnt_pkg::*;

    `include "assert_macros.svh"

    localparam int CW     = $clog2(MAX_CITIES);
    localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
    localparam int AW     = $clog2(DEPTH);
    localparam int LIMIT  = (MAX_CITIES < RESULT_LIMIT) ? MAX_CITIES : RESULT_LIMIT;
    localparam int LOAD_W = (DIST_BITS > 16) ? DIST_BITS : 16;
    localparam int SUM_W  = ((COST_W > DIST_BITS) ? COST_W : DIST_BITS) + 1;
    localparam int RANGE_W = CW + 2;

    // Distance memory and its registered read port.
    logic [DIST_BITS-1:0] dist_mem [DEPTH];
    logic [DIST_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    logic [LOAD_W-1:0]    load_ext;

    // Sequencer and tour state.
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   city_count_reg;
    logic [COUNT_W-1:0]   n_reg, n_next;
    logic [CW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        first_reg, first_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [CITY_W-1:0]    pos_reg, pos_next;
    logic [MAX_CITIES-1:0] visited_reg, visited_next;
    logic [COST_W-1:0]    cost_reg, cost_next;

    // Compare unit state.
    logic                 rd_valid_reg, rd_valid_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [DIST_BITS-1:0] best_reg, best_next;
    logic [CW-1:0]        pick_reg, pick_next;

    // Output beat registers.
    logic [CITY_W-1:0]    position_reg, position_next;
    logic [CITY_W-1:0]    city_reg, city_next;
    logic                 last_reg, last_next;
    logic [COST_W-1:0]    tour_cost_reg, tour_cost_next;

    // Shared saturating adder.
    logic [DIST_BITS-1:0] add_b;
    logic [SUM_W-1:0]     sum_wide;
    logic [COST_W-1:0]    sum_sat;

    // Solve set-up values.
    logic [COUNT_W-1:0]   n_clamp;
    logic [CW-1:0]        start_sel;
    logic                 take;
    logic                 in_fire;
    logic                 load_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign position  = position_reg;
    assign city      = city_reg;
    assign last      = last_reg;
    assign tour_cost = tour_cost_reg;
    assign in_fire   = in_valid && in_ready;

    // Load path: entries outside the matrix are dropped.
    assign load_ext = LOAD_W'(distance);
    assign load_ok  = (RANGE_W'(from_city) < RANGE_W'(MAX_CITIES)) &&
                      (RANGE_W'(to_city) < RANGE_W'(MAX_CITIES));
    assign wr_en    = in_fire && (operation == OP_LOAD) && load_ok;
    assign wr_addr  = AW'(from_city) * AW'(MAX_CITIES) + AW'(to_city);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wr_addr] <= load_ext[DIST_BITS-1:0];
        end
        rd_data_reg <= dist_mem[rd_addr];
    end

    // Read address: scan column during a scan, else the return edge.
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            rd_addr = AW'(cur_reg) * AW'(MAX_CITIES) + AW'(j_reg);
        end
        else
        begin
            rd_addr = AW'(cur_reg) * AW'(MAX_CITIES) + AW'(first_reg);
        end
    end

    // City count in use and the start city it allows.
    always_comb
    begin
        if (city_count_reg == '0)
        begin
            n_clamp = COUNT_W'(1);
        end
        else if (city_count_reg > COUNT_W'(LIMIT))
        begin
            n_clamp = COUNT_W'(LIMIT);
        end
        else
        begin
            n_clamp = city_count_reg;
        end
        if (COUNT_W'(start_city) >= n_clamp)
        begin
            start_sel = '0;
        end
        else
        begin
            start_sel = CW'(start_city);
        end
    end

    // Compare unit: keeps the nearest unvisited city, lowest index on a tie.
    assign take = rd_valid_reg && !visited_reg[rd_idx_reg] &&
                  (!found_reg || (rd_data_reg < best_reg));

    // Saturating cost adder, fed by the chosen edge or the return edge.
    assign add_b    = (state_reg == S_RETW) ? rd_data_reg : best_reg;
    assign sum_wide = SUM_W'(cost_reg) + SUM_W'(add_b);
    assign sum_sat  = (sum_wide > SUM_W'(COST_MAX)) ? COST_MAX : sum_wide[COST_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        visited_next   = visited_reg;
        cost_next      = cost_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        position_next  = position_reg;
        city_next      = city_reg;
        last_next      = last_reg;
        tour_cost_next = tour_cost_reg;

        if (take)
        begin
            found_next = 1'b1;
            best_next  = rd_data_reg;
            pick_next  = rd_idx_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (operation == OP_SOLVE))
                begin
                    n_next                  = n_clamp;
                    cur_next                = start_sel;
                    first_next              = start_sel;
                    pos_next                = '0;
                    visited_next            = '0;
                    visited_next[start_sel] = 1'b1;
                    cost_next               = '0;
                    position_next           = '0;
                    city_next               = CITY_W'(start_sel);
                    last_next               = 1'b0;
                    tour_cost_next          = '0;
                    if (n_clamp == COUNT_W'(1))
                    begin
                        state_next = S_RET;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_SCAN:
            begin
                rd_valid_next = 1'b1;
                rd_idx_next   = j_reg;
                j_next        = j_reg + CW'(1);
                if (COUNT_W'(j_reg) == n_reg - COUNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cost_next              = sum_sat;
                cur_next               = pick_reg;
                visited_next[pick_reg] = 1'b1;
                pos_next               = pos_reg + CITY_W'(1);
                position_next          = pos_reg + CITY_W'(1);
                city_next              = CITY_W'(pick_reg);
                if (COUNT_W'(pos_reg) + COUNT_W'(1) == n_reg - COUNT_W'(1))
                begin
                    state_next = S_RET;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_RET:
            begin
                state_next = S_RETW;
            end
            S_RETW:
            begin
                cost_next      = sum_sat;
                last_next      = 1'b1;
                tour_cost_next = sum_sat;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            city_count_reg <= CITY_COUNT_RESET;
            n_reg          <= CITY_COUNT_RESET;
            cur_reg        <= '0;
            first_reg      <= '0;
            j_reg          <= '0;
            pos_reg        <= '0;
            visited_reg    <= '0;
            cost_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                city_count_reg <= cfg_wdata;
            end
            n_reg        <= n_next;
            cur_reg      <= cur_next;
            first_reg    <= first_next;
            j_reg        <= j_next;
            pos_reg      <= pos_next;
            visited_reg  <= visited_next;
            cost_reg     <= cost_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            last_reg     <= last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        position_reg  <= position_next;
        city_reg      <= city_next;
        tour_cost_reg <= tour_cost_next;
    end

    // The block never takes an input beat while an output beat is pending.
    `ASSERT_CLKED(a_one_item, clk, rst_n, !(in_ready && out_valid), "input ready while output valid")
    // The final beat sits at the last position of the tour.
    `ASSERT_CLKED(a_last_pos, clk, rst_n, (out_valid && last) |-> (COUNT_W'(position) == n_reg - COUNT_W'(1)), "last beat at wrong position")
    // Only the final beat carries a cost.
    `ASSERT_CLKED(a_cost_zero, clk, rst_n, (out_valid && !last) |-> (tour_cost == '0), "cost on a non-final beat")
    // Every scan finds an unvisited city.
    `ASSERT_CLKED(a_found, clk, rst_n, (state_reg == S_PICK) |-> found_reg, "scan found no city")

endmodule
